[sv/sal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and field widths of the suffix array / LCP builder.
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int KIND_W   = 2;
	localparam int SYMBOL_W = 8;
	localparam int FIELD_W  = 11;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_DATA,
		ST_INIT_RD,
		ST_INIT_WR,
		ST_REC_R1,
		ST_REC_R2,
		ST_REC_W,
		ST_MS_SETUP,
		ST_MS_RA,
		ST_MS_RB,
		ST_MS_PICK,
		ST_CP_R,
		ST_CP_W,
		ST_RR_R,
		ST_RR_W,
		ST_INV_R,
		ST_INV_W,
		ST_LCP0,
		ST_K_R1,
		ST_K_R2,
		ST_K_H,
		ST_K_C1,
		ST_K_C2,
		ST_K_C3,
		ST_K_W,
		ST_DONE
	} state_t;

endpackage

[sv/sal_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_item_if
// Input channel: append, finish and read words.
// ----------------------------------------------------------------------------
interface sal_item_if;
	logic                         valid;
	logic                         ready;
	logic [sal_pkg::KIND_W-1:0]   kind;
	logic [sal_pkg::SYMBOL_W-1:0] symbol;
	logic [sal_pkg::FIELD_W-1:0]  entry_index;

	modport source(output valid, kind, symbol, entry_index, input ready);
	modport sink(input valid, kind, symbol, entry_index, output ready);
endinterface

[sv/sal_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_result_if
// Output channel: one word per read item.
// ----------------------------------------------------------------------------
interface sal_result_if;
	logic                        valid;
	logic                        ready;
	logic [sal_pkg::FIELD_W-1:0] suffix_start;
	logic [sal_pkg::FIELD_W-1:0] common_prefix;
	logic                        range_error;
	logic                        overflow_seen;

	modport source(output valid, suffix_start, common_prefix, range_error, overflow_seen,
		input ready);
	modport sink(input valid, suffix_start, common_prefix, range_error, overflow_seen,
		output ready);
endinterface

[sv/sal_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sal_ram #(
	parameter int DEPTH = 1025,
	parameter int DW    = 11,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/suffix_array_lcp_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder
// Loads a text, sorts its suffixes by prefix doubling with a merge sort and
// builds the LCP table with Kasai's walk; reads return one table entry.
// ----------------------------------------------------------------------------
// channel  dir  fields
// item     in   kind, symbol, entry_index
// result   out  suffix_start, common_prefix, range_error, overflow_seen
//
// append writes the text on acceptance; read looks up its entry, then hands off a result.
// finish runs a sequencer over simple dual-port memories: an init pass,
// then per doubling round a key build, ceil(log2(n+1)) merge passes each
// followed by a copy back, and a rerank; then an inverse pass and Kasai,
// one text position at a time, comparing byte by byte until a mismatch.
// one key comparator serves the merge.
// item.ready is low during a build, during a read lookup and while a result word waits.
// arst_n clears length, flags, sequencer and output valid.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder #(
	parameter int MAX_LEN = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	sal_item_if.sink       item,
	sal_result_if.source   result
);

	localparam int LW    = $clog2(MAX_LEN + 1);
	localparam int XW    = (LW > sal_pkg::FIELD_W) ? LW : sal_pkg::FIELD_W;
	localparam int RW    = (LW > 9) ? LW : 9;
	localparam int KYW   = 2 * RW + 1;
	localparam int RCW   = KYW + LW;
	localparam int CW    = LW + 2;
	localparam int DEPTH = MAX_LEN + 1;

	sal_pkg::state_t state_q, state_d;

	logic [LW-1:0] n_q;
	logic          built_q, ovf_q;
	logic          out_valid_q;
	logic [sal_pkg::FIELD_W-1:0] out_start_q, out_cp_q;
	logic          out_err_q, out_ovf_q;

	logic [LW-1:0]  i_q, r_q, j_q, h_q;
	logic [LW:0]    k_q;
	logic [CW-1:0]  w_q, lo_q, mid_q, hi_q, a_q, b_q, o_q;
	logic [RW-1:0]  k1_q, nr_q;
	logic [RCW-1:0] ra_q;
	logic [KYW-1:0] pk_q;
	logic [sal_pkg::SYMBOL_W-1:0] tj_q;

	// memory ports
	logic                         txt_we, rnk_we, ord_we, lcp_we, ra_we, rb_we;
	logic [LW-1:0]                txt_wa, rnk_wa, ord_wa, lcp_wa, ra_wa, rb_wa;
	logic [LW-1:0]                txt_ra, rnk_ra, ord_ra, lcp_ra, ra_ra, rb_ra;
	logic [sal_pkg::SYMBOL_W-1:0] txt_wd, txt_rd;
	logic [RW-1:0]                rnk_wd, rnk_rd;
	logic [LW-1:0]                ord_wd, ord_rd, lcp_wd, lcp_rd;
	logic [RCW-1:0]               ra_wd, ra_rd, rb_wd, rb_rd;

	sal_ram #(.DEPTH(DEPTH), .DW(sal_pkg::SYMBOL_W), .AW(LW)) u_text (
		.clk(clk), .we(txt_we), .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));
	sal_ram #(.DEPTH(DEPTH), .DW(RW), .AW(LW)) u_rank (
		.clk(clk), .we(rnk_we), .waddr(rnk_wa), .wdata(rnk_wd), .raddr(rnk_ra), .rdata(rnk_rd));
	sal_ram #(.DEPTH(DEPTH), .DW(LW), .AW(LW)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
	sal_ram #(.DEPTH(DEPTH), .DW(LW), .AW(LW)) u_lcp (
		.clk(clk), .we(lcp_we), .waddr(lcp_wa), .wdata(lcp_wd), .raddr(lcp_ra), .rdata(lcp_rd));
	sal_ram #(.DEPTH(DEPTH), .DW(RCW), .AW(LW)) u_reca (
		.clk(clk), .we(ra_we), .waddr(ra_wa), .wdata(ra_wd), .raddr(ra_ra), .rdata(ra_rd));
	sal_ram #(.DEPTH(DEPTH), .DW(RCW), .AW(LW)) u_recb (
		.clk(clk), .we(rb_we), .waddr(rb_wa), .wdata(rb_wd), .raddr(rb_ra), .rdata(rb_rd));

	// shared helpers
	logic          acc;
	logic          rd_err;
	logic [CW-1:0] cnt;
	logic [CW-1:0] mid_c, hi_c, lo_nx, w_nx;
	logic [LW:0]   ik, jh, ih, k_nx;
	logic          i_last, k_last;
	logic          a_ok, b_ok, take_b, seg_done;
	logic          guard, key_ne;
	logic [KYW-1:0] cur_key;
	logic [RW:0]   second;

	assign item.ready = (state_q == sal_pkg::ST_IDLE) && !out_valid_q;
	assign acc        = item.valid && item.ready;
	assign rd_err     = !built_q || (XW'(item.entry_index) > XW'(n_q));
	assign cnt        = CW'(n_q) + CW'(1);
	assign mid_c      = ((lo_q + w_q) < cnt) ? (lo_q + w_q) : cnt;
	assign hi_c       = ((mid_c + w_q) < cnt) ? (mid_c + w_q) : cnt;
	assign lo_nx      = lo_q + (w_q << 1);
	assign w_nx       = w_q << 1;
	assign k_nx       = k_q << 1;
	assign ik         = (LW+1)'(i_q) + k_q;
	assign jh         = (LW+1)'(j_q) + (LW+1)'(h_q);
	assign ih         = (LW+1)'(i_q) + (LW+1)'(h_q);
	assign i_last     = (i_q == n_q);
	assign k_last     = (k_nx > (LW+1)'(n_q));
	assign a_ok       = a_q < mid_q;
	assign b_ok       = b_q < hi_q;
	// the one key comparator used by every merge step
	assign take_b     = b_ok && (!a_ok || (ra_rd[RCW-1:LW] < ra_q[RCW-1:LW]));
	assign seg_done   = (o_q + CW'(1)) == hi_q;
	assign guard      = (jh < (LW+1)'(n_q)) && (ih < (LW+1)'(n_q));
	assign cur_key    = ra_rd[RCW-1:LW];
	assign key_ne     = cur_key != pk_q;
	assign second     = (ik <= (LW+1)'(n_q)) ? ((RW+1)'(rnk_rd) + (RW+1)'(1)) : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sal_pkg::ST_IDLE: begin
				if (acc && item.kind == sal_pkg::KIND_FINISH) begin
					state_d = sal_pkg::ST_INIT_RD;
				end else if (acc && item.kind == sal_pkg::KIND_READ && !rd_err) begin
					state_d = sal_pkg::ST_RD_DATA;
				end
			end
			sal_pkg::ST_RD_DATA:  state_d = sal_pkg::ST_IDLE;
			sal_pkg::ST_INIT_RD:  state_d = sal_pkg::ST_INIT_WR;
			sal_pkg::ST_INIT_WR: begin
				if (!i_last) state_d = sal_pkg::ST_INIT_RD;
				else if (n_q != '0) state_d = sal_pkg::ST_REC_R1;
				else state_d = sal_pkg::ST_INV_R;
			end
			sal_pkg::ST_REC_R1:   state_d = sal_pkg::ST_REC_R2;
			sal_pkg::ST_REC_R2:   state_d = sal_pkg::ST_REC_W;
			sal_pkg::ST_REC_W:    state_d = i_last ? sal_pkg::ST_MS_SETUP : sal_pkg::ST_REC_R1;
			sal_pkg::ST_MS_SETUP: state_d = sal_pkg::ST_MS_RA;
			sal_pkg::ST_MS_RA:    state_d = sal_pkg::ST_MS_RB;
			sal_pkg::ST_MS_RB:    state_d = sal_pkg::ST_MS_PICK;
			sal_pkg::ST_MS_PICK: begin
				if (!seg_done) state_d = sal_pkg::ST_MS_RA;
				else if (lo_nx < cnt) state_d = sal_pkg::ST_MS_SETUP;
				else state_d = sal_pkg::ST_CP_R;
			end
			sal_pkg::ST_CP_R:     state_d = sal_pkg::ST_CP_W;
			sal_pkg::ST_CP_W: begin
				if (!i_last) state_d = sal_pkg::ST_CP_R;
				else if (w_nx < cnt) state_d = sal_pkg::ST_MS_SETUP;
				else state_d = sal_pkg::ST_RR_R;
			end
			sal_pkg::ST_RR_R:     state_d = sal_pkg::ST_RR_W;
			sal_pkg::ST_RR_W: begin
				if (!i_last) state_d = sal_pkg::ST_RR_R;
				else if (!k_last) state_d = sal_pkg::ST_REC_R1;
				else state_d = sal_pkg::ST_INV_R;
			end
			sal_pkg::ST_INV_R:    state_d = sal_pkg::ST_INV_W;
			sal_pkg::ST_INV_W:    state_d = i_last ? sal_pkg::ST_LCP0 : sal_pkg::ST_INV_R;
			sal_pkg::ST_LCP0:     state_d = (n_q == '0) ? sal_pkg::ST_DONE : sal_pkg::ST_K_R1;
			sal_pkg::ST_K_R1:     state_d = sal_pkg::ST_K_R2;
			sal_pkg::ST_K_R2:     state_d = sal_pkg::ST_K_H;
			sal_pkg::ST_K_H:      state_d = sal_pkg::ST_K_C1;
			sal_pkg::ST_K_C1:     state_d = guard ? sal_pkg::ST_K_C2 : sal_pkg::ST_K_W;
			sal_pkg::ST_K_C2:     state_d = sal_pkg::ST_K_C3;
			sal_pkg::ST_K_C3:     state_d = (txt_rd == tj_q) ? sal_pkg::ST_K_C1 : sal_pkg::ST_K_W;
			sal_pkg::ST_K_W: begin
				state_d = ((i_q + LW'(1)) == n_q) ? sal_pkg::ST_DONE : sal_pkg::ST_K_R1;
			end
			sal_pkg::ST_DONE:     state_d = sal_pkg::ST_IDLE;
			default:              state_d = sal_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		txt_we = 1'b0; txt_wa = n_q; txt_wd = item.symbol; txt_ra = i_q;
		rnk_we = 1'b0; rnk_wa = i_q; rnk_wd = '0;          rnk_ra = i_q;
		ord_we = 1'b0; ord_wa = i_q; ord_wd = i_q;         ord_ra = LW'(item.entry_index);
		lcp_we = 1'b0; lcp_wa = n_q; lcp_wd = '0;          lcp_ra = LW'(item.entry_index);
		ra_we  = 1'b0; ra_wa  = i_q; ra_wd  = rb_rd;       ra_ra  = i_q;
		rb_we  = 1'b0; rb_wa  = LW'(o_q); rb_wd = take_b ? ra_rd : ra_q; rb_ra = i_q;
		case (state_q)
			sal_pkg::ST_IDLE: begin
				txt_we = acc && item.kind == sal_pkg::KIND_APPEND && (n_q < LW'(MAX_LEN));
			end
			sal_pkg::ST_INIT_WR: begin
				rnk_we = 1'b1;
				rnk_wd = (i_q < n_q) ? (RW'(txt_rd) + RW'(1)) : '0;
				ord_we = 1'b1;
			end
			sal_pkg::ST_REC_R2:  rnk_ra = LW'(ik);
			sal_pkg::ST_REC_W: begin
				ra_we = 1'b1;
				ra_wd = {k1_q, second, i_q};
			end
			sal_pkg::ST_MS_RA:   ra_ra = LW'(a_q);
			sal_pkg::ST_MS_RB:   ra_ra = LW'(b_q);
			sal_pkg::ST_MS_PICK: rb_we = 1'b1;
			sal_pkg::ST_CP_W:    ra_we = 1'b1;
			sal_pkg::ST_RR_W: begin
				rnk_we = 1'b1;
				rnk_wa = ra_rd[LW-1:0];
				rnk_wd = (i_q == '0) ? '0 : (nr_q + RW'(key_ne));
				ord_we = 1'b1;
				ord_wd = ra_rd[LW-1:0];
			end
			sal_pkg::ST_INV_R:   ord_ra = i_q;
			sal_pkg::ST_INV_W: begin
				rnk_we = 1'b1;
				rnk_wa = ord_rd;
				rnk_wd = RW'(i_q);
			end
			sal_pkg::ST_LCP0:    lcp_we = 1'b1;
			sal_pkg::ST_K_R2:    ord_ra = LW'(rnk_rd) - LW'(1);
			sal_pkg::ST_K_C1:    txt_ra = LW'(jh);
			sal_pkg::ST_K_C2:    txt_ra = LW'(ih);
			sal_pkg::ST_K_W: begin
				lcp_we = 1'b1;
				lcp_wa = r_q - LW'(1);
				lcp_wd = h_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sal_pkg::ST_IDLE;
			n_q         <= '0;
			built_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sal_pkg::ST_IDLE && acc) begin
				if (item.kind == sal_pkg::KIND_APPEND) begin
					built_q <= 1'b0;
					if (n_q < LW'(MAX_LEN)) n_q <= n_q + LW'(1);
					else ovf_q <= 1'b1;
				end else if (item.kind == sal_pkg::KIND_READ && rd_err) begin
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == sal_pkg::ST_RD_DATA) out_valid_q <= 1'b1;
			if (state_q == sal_pkg::ST_DONE) built_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sal_pkg::ST_IDLE: begin
				i_q <= '0;
				if (acc && item.kind == sal_pkg::KIND_READ) begin
					out_start_q <= '0;
					out_cp_q    <= '0;
					out_err_q   <= 1'b1;
					out_ovf_q   <= ovf_q;
				end
			end
			sal_pkg::ST_RD_DATA: begin
				out_start_q <= sal_pkg::FIELD_W'(ord_rd);
				out_cp_q    <= sal_pkg::FIELD_W'(lcp_rd);
				out_err_q   <= 1'b0;
				out_ovf_q   <= ovf_q;
			end
			sal_pkg::ST_INIT_WR: begin
				i_q <= i_last ? '0 : i_q + LW'(1);
				k_q <= (LW+1)'(1);
			end
			sal_pkg::ST_REC_R2:  k1_q <= rnk_rd;
			sal_pkg::ST_REC_W: begin
				i_q  <= i_last ? '0 : i_q + LW'(1);
				w_q  <= CW'(1);
				lo_q <= '0;
			end
			sal_pkg::ST_MS_SETUP: begin
				mid_q <= mid_c;
				hi_q  <= hi_c;
				a_q   <= lo_q;
				b_q   <= mid_c;
				o_q   <= lo_q;
			end
			sal_pkg::ST_MS_RB:   ra_q <= ra_rd;
			sal_pkg::ST_MS_PICK: begin
				o_q <= o_q + CW'(1);
				if (take_b) b_q <= b_q + CW'(1);
				else a_q <= a_q + CW'(1);
				if (seg_done) lo_q <= lo_nx;
				i_q <= '0;
			end
			sal_pkg::ST_CP_W: begin
				i_q <= i_last ? '0 : i_q + LW'(1);
				if (i_last) begin
					w_q  <= w_nx;
					lo_q <= '0;
				end
			end
			sal_pkg::ST_RR_W: begin
				i_q  <= i_last ? '0 : i_q + LW'(1);
				nr_q <= (i_q == '0) ? '0 : (nr_q + RW'(key_ne));
				pk_q <= cur_key;
				if (i_last) k_q <= k_nx;
			end
			sal_pkg::ST_INV_W:   i_q <= i_last ? '0 : i_q + LW'(1);
			sal_pkg::ST_LCP0: begin
				i_q <= '0;
				h_q <= '0;
			end
			sal_pkg::ST_K_R2:    r_q <= LW'(rnk_rd);
			sal_pkg::ST_K_H: begin
				j_q <= ord_rd;
				if (h_q != '0) h_q <= h_q - LW'(1);
			end
			sal_pkg::ST_K_C2:    tj_q <= txt_rd;
			sal_pkg::ST_K_C3: begin
				if (txt_rd == tj_q) h_q <= h_q + LW'(1);
			end
			sal_pkg::ST_K_W:     i_q <= i_q + LW'(1);
			default: begin
			end
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.suffix_start  = out_start_q;
	assign result.common_prefix = out_cp_q;
	assign result.range_error   = out_err_q;
	assign result.overflow_seen = out_ovf_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> state_q == sal_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= LW'(MAX_LEN))
		else $error("text length beyond capacity");
	a_build_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sal_pkg::ST_DONE |=> built_q)
		else $error("build end did not mark arrays valid");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.range_error |->
		result.suffix_start == '0 && result.common_prefix == '0)
		else $error("error word carries data");
	a_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sal_pkg::ST_K_W |-> h_q <= n_q)
		else $error("common prefix longer than text");
`endif

endmodule

[tb/tb_suffix_array_lcp_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_suffix_array_lcp_builder
// Loads short random texts and one full-capacity text, builds suffix and LCP tables and reads entries
// back; a scoreboard holds its own table model and checks every result word.
// ----------------------------------------------------------------------------
module tb_suffix_array_lcp_builder;

	localparam int CAP = 1024;

	typedef struct packed {
		logic [sal_pkg::FIELD_W-1:0] suffix_start;
		logic [sal_pkg::FIELD_W-1:0] common_prefix;
		logic                        range_error;
		logic                        overflow_seen;
	} entry_word_t;

	class lcp_scoreboard;
		byte unsigned text[CAP];
		int unsigned  len;
		bit           built;
		bit           ovf;
		int unsigned  sa[CAP + 1];
		int unsigned  lcp[CAP + 1];
		entry_word_t  pending[$];
		int unsigned  errors;
		int unsigned  checked;

		function void clear();
			len = 0;
			built = 0;
			ovf = 0;
		endfunction

		// suffix compare with the empty suffix lowest
		function bit suffix_less(int unsigned a, int unsigned b);
			int unsigned p;
			p = 0;
			while (a + p < len && b + p < len && text[a + p] == text[b + p])
				p++;
			if (a + p >= len)
				return b + p < len;
			if (b + p >= len)
				return 0;
			return text[a + p] < text[b + p];
		endfunction

		function void build_tables();
			int unsigned i, j, t, h;
			for (i = 0; i <= len; i++)
				sa[i] = i;
			for (i = 1; i <= len; i++) begin
				t = sa[i];
				j = i;
				while (j > 0 && suffix_less(t, sa[j - 1])) begin
					sa[j] = sa[j - 1];
					j--;
				end
				sa[j] = t;
			end
			for (i = 0; i <= len; i++) begin
				h = 0;
				if (i < len)
					while (sa[i] + h < len && sa[i + 1] + h < len &&
						text[sa[i] + h] == text[sa[i + 1] + h])
						h++;
				lcp[i] = h;
			end
			built = 1;
		endfunction

		function void note_item(sal_pkg::kind_t k, byte unsigned s, int unsigned idx);
			entry_word_t w;
			case (k)
				sal_pkg::KIND_APPEND: begin
					if (len < CAP) begin
						text[len] = s;
						len++;
					end else
						ovf = 1;
					built = 0;
				end
				sal_pkg::KIND_FINISH: build_tables();
				sal_pkg::KIND_READ: begin
					w = '0;
					if (!built || idx > len)
						w.range_error = 1;
					else begin
						w.suffix_start = sa[idx];
						w.common_prefix = lcp[idx];
					end
					w.overflow_seen = ovf;
					pending.push_back(w);
				end
				default: ;
			endcase
		endfunction

		function void check_word(entry_word_t got);
			entry_word_t w;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (w != got) begin
				$display("%0t: mismatch expected start %0d lcp %0d err %0d ovf %0d",
					$time, w.suffix_start, w.common_prefix, w.range_error, w.overflow_seen);
				$display("%0t:          actual   start %0d lcp %0d err %0d ovf %0d",
					$time, got.suffix_start, got.common_prefix, got.range_error,
					got.overflow_seen);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	sal_item_if   item();
	sal_result_if result();
	lcp_scoreboard sb = new();
	int unsigned   sent;

	suffix_array_lcp_builder #(.MAX_LEN(CAP)) dut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result)
	);

	always #2 clk = ~clk;

	function automatic int unsigned gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
	endfunction

	// valid stays high across back to back words and drops only for a gap
	task automatic send_word(logic [1:0] k, logic [7:0] s, logic [10:0] idx);
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			item.valid <= 0;
			repeat (g) @(posedge clk);
		end
		item.valid <= 1;
		item.kind <= k;
		item.symbol <= s;
		item.entry_index <= idx;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		sb.note_item(sal_pkg::kind_t'(k), s, idx);
		sent++;
	endtask

	// random text, build, then a burst of reads mostly in range
	task automatic text_round(int unsigned n, int unsigned reads, int unsigned alpha);
		int unsigned i;
		for (i = 0; i < n; i++)
			send_word(sal_pkg::KIND_APPEND,
				(alpha == 0) ? 8'($urandom) : 8'($urandom_range(0, alpha)), '0);
		send_word(sal_pkg::KIND_FINISH, 8'($urandom), 11'($urandom));
		for (i = 0; i < reads; i++)
			send_word(sal_pkg::KIND_READ, 8'($urandom),
				($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, n + 1)));
	endtask

	initial begin
		item.valid = 0;
		item.kind = sal_pkg::KIND_APPEND;
		item.symbol = 0;
		item.entry_index = 0;
		result.ready = 0;
		sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: read before build, empty text, kind 3, extremes
		send_word(sal_pkg::KIND_READ, 8'hff, 11'd0);
		send_word(2'd3, 8'hff, 11'h7ff);
		send_word(sal_pkg::KIND_FINISH, 8'h00, 11'd0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd1);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'h7ff);
		send_word(sal_pkg::KIND_APPEND, 8'hff, 11'd0);
		send_word(sal_pkg::KIND_APPEND, 8'h00, 11'd0);
		send_word(sal_pkg::KIND_APPEND, 8'hff, 11'd0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd0);
		send_word(sal_pkg::KIND_FINISH, 8'h00, 11'd0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd1);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd2);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd3);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd4);
		send_word(sal_pkg::KIND_APPEND, 8'h80, 11'd0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd1);
		// random texts, mostly small alphabets for long common prefixes
		while (sent < 1000)
			text_round($urandom_range(0, 24), $urandom_range(4, 30),
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
		// fill to capacity and past it, then build and read the largest text
		while (sb.len < CAP)
			send_word(sal_pkg::KIND_APPEND, 8'($urandom_range(0, 1)), '0);
		send_word(sal_pkg::KIND_APPEND, 8'($urandom), '0);
		send_word(sal_pkg::KIND_APPEND, 8'($urandom), '0);
		send_word(sal_pkg::KIND_FINISH, 8'h00, '0);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd1024);
		send_word(sal_pkg::KIND_READ, 8'h00, 11'd1025);
		repeat (60)
			send_word(sal_pkg::KIND_READ, 8'($urandom), 11'($urandom_range(0, 1024)));
		send_word(2'd3, 8'($urandom), 11'($urandom));
		item.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d input words, checked %0d result words", sent, sb.checked);
		$display("covered empty and full texts, overflow, unbuilt and out-of-range reads");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls, stretches of constant ready
	initial begin
		int unsigned g;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready)
				sb.check_word({result.suffix_start, result.common_prefix,
					result.range_error, result.overflow_seen});
			g = 0;
			if ($urandom_range(0, 7) == 0)
				g = gap_len();
			if (g > 0) begin
				result.ready <= 0;
				repeat (g) @(posedge clk);
			end
			result.ready <= 1;
		end
	end

	initial begin
		#1s;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
